@@ rtl/ecal_pkg.sv @@
package ecal_pkg;

  // Number of register stages from the input register to the output register.
  localparam int unsigned STAGES = 11;

  // Largest input that is not saturated: 9999-12-31 23:59:59.
  localparam logic [37:0] T_MAX = 38'd253402300799;

  localparam logic [9:0]  SECS_PER_DAY_ODD = 10'd675;  // 86400 = 675 * 128
  localparam logic [21:0] MARCH_SHIFT      = 22'd719468; // 719527 - (31 + 28)
  localparam logic [17:0] CYCLE_DAYS       = 18'd146097;
  localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
  localparam logic [8:0]  MARCH_YEAR_DAYS  = 9'd306;

  // Truncated reciprocals: x * R >> K is the quotient or one less for x < 2**K.
  localparam logic [30:0] RECIP_DAY  = 31'((64'd1 << 40) / 64'd675);
  localparam logic [22:0] RECIP_7    = 23'((64'd1 << 25) / 64'd7);
  localparam logic [17:0] RECIP_HOUR = 18'((64'd1 << 29) / 64'd3600);
  localparam logic [13:0] RECIP_CYC  = 14'((64'd1 << 31) / 64'd146097);
  localparam logic [10:0] RECIP_60   = 11'((64'd1 << 16) / 64'd60);

  // Rounded-up reciprocals that give the exact quotient over the used range.
  localparam logic [12:0] RECIP_100  = 13'd5243;  // shift 19, exact below 43699
  localparam logic [11:0] RECIP_306  = 12'd3427;  // shift 20, exact below 12192

  typedef struct packed {
    logic [STAGES-1:0] en;
  } ecal_pipe_t;

  // 367 * m / 12, floor: 30 + days from March 1 to month m (March is 1).
  function automatic logic [8:0] ecal_mon_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ecal_pipe_ctrl.sv @@
module ecal_pipe_ctrl
  import ecal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output ecal_pipe_t pipe
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // A stage loads when it is empty or when the stage after it loads, so bubbles
  // are squeezed out while the output waits.
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];
  assign pipe.en   = en;

endmodule

@@ rtl/epoch_seconds_to_calendar_core.sv @@
// Converts a signed count of seconds since 1970-01-01 00:00:00 UTC into second,
// minute, hour, day of month, month, year and weekday (0 is Sunday). Negative
// counts read as the epoch itself, and counts past 9999-12-31 23:59:59 read as
// that instant. The core takes one request per clock cycle while its output
// is taken or empty stages remain; each result passes through a chain of
// eleven register stages from the input register to the output register, most
// of them built around one constant-reciprocal multiply and its correction.
// A stalled output does not block the input while empty stages remain. There
// is no configuration and nothing to initialize.
module epoch_seconds_to_calendar_core
  import ecal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [63:0] epoch_seconds,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        second,
  output logic [5:0]        minute,
  output logic [4:0]        hour,
  output logic [4:0]        day_of_month,
  output logic [3:0]        month,
  output logic [13:0]       year,
  output logic [2:0]        weekday
);

  ecal_pipe_t pipe;

  ecal_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pipe      (pipe)
  );

  // Stage 0: clamp.
  logic [37:0] s0_t;
  logic [37:0] t_clamp;

  always_comb begin
    if (epoch_seconds[63]) begin
      t_clamp = '0;
    end else if (epoch_seconds > $signed({26'd0, T_MAX})) begin
      t_clamp = T_MAX;
    end else begin
      t_clamp = epoch_seconds[37:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en[0]) begin
      s0_t <= t_clamp;
    end
  end

  // Stage 1: day estimate from the seconds divided by 128, then by 675.
  logic [61:0] prod_day;
  logic [21:0] s1_q;
  logic [37:0] s1_t;

  assign prod_day = 62'(s0_t[37:7]) * 62'(RECIP_DAY);

  always_ff @(posedge clk) begin
    if (pipe.en[1]) begin
      s1_q <= prod_day[61:40];
      s1_t <= s0_t;
    end
  end

  // Stage 2: correct the day count and form the second of the day.
  logic [31:0] q675;
  logic [30:0] rem_day_full;
  logic [10:0] rem_day;
  logic        fix_day;
  logic [21:0] s2_days;
  logic [16:0] s2_sec;

  assign q675         = 32'(s1_q) * 32'(SECS_PER_DAY_ODD);
  assign rem_day_full = s1_t[37:7] - q675[30:0];
  assign rem_day      = rem_day_full[10:0];
  assign fix_day      = rem_day >= 11'(SECS_PER_DAY_ODD);

  always_ff @(posedge clk) begin
    if (pipe.en[2]) begin
      if (fix_day) begin
        s2_days <= s1_q + 22'd1;
        s2_sec  <= {10'(rem_day - 11'(SECS_PER_DAY_ODD)), s1_t[6:0]};
      end else begin
        s2_days <= s1_q;
        s2_sec  <= {rem_day[9:0], s1_t[6:0]};
      end
    end
  end

  // Stage 3: March-based day, year numerator, weekday and hour estimates.
  logic [21:0] wx;
  logic [44:0] prod_w;
  logic [21:0] d_march;
  logic [34:0] prod_h;
  logic [21:0] s3_wx;
  logic [19:0] s3_w0;
  logic [21:0] s3_d;
  logic [30:0] s3_n;
  logic [4:0]  s3_h0;
  logic [16:0] s3_sec;

  assign wx      = s2_days + 22'd4;
  assign prod_w  = 45'(wx) * 45'(RECIP_7);
  assign d_march = s2_days + MARCH_SHIFT;
  assign prod_h  = 35'(s2_sec) * 35'(RECIP_HOUR);

  always_ff @(posedge clk) begin
    if (pipe.en[3]) begin
      s3_wx  <= wx;
      s3_w0  <= prod_w[44:25];
      s3_d   <= d_march;
      s3_n   <= (31'(d_march) + 31'd2) * 31'd400;
      s3_h0  <= prod_h[33:29];
      s3_sec <= s2_sec;
    end
  end

  // Stage 4: year estimate; correct weekday and hour.
  logic [44:0] prod_y;
  logic [23:0] w7;
  logic [21:0] wr_full;
  logic [3:0]  wr;
  logic [16:0] h3600;
  logic [16:0] hr_full;
  logic [12:0] hr;
  logic [13:0] s4_y0;
  logic [30:0] s4_n;
  logic [21:0] s4_d;
  logic [2:0]  s4_wday;
  logic [4:0]  s4_hour;
  logic [11:0] s4_s2;

  assign prod_y  = 45'(s3_n) * 45'(RECIP_CYC);
  assign w7      = 24'(s3_w0) * 24'd7;
  assign wr_full = s3_wx - w7[21:0];
  assign wr      = wr_full[3:0];
  assign h3600   = 17'(s3_h0) * 17'(SECS_PER_HOUR);
  assign hr_full = s3_sec - h3600;
  assign hr      = hr_full[12:0];

  always_ff @(posedge clk) begin
    if (pipe.en[4]) begin
      s4_y0 <= prod_y[44:31];
      s4_n  <= s3_n;
      s4_d  <= s3_d;
      if (wr >= 4'd7) begin
        s4_wday <= 3'(wr - 4'd7);
      end else begin
        s4_wday <= wr[2:0];
      end
      if (hr >= 13'(SECS_PER_HOUR)) begin
        s4_hour <= s3_h0 + 5'd1;
        s4_s2   <= 12'(hr - 13'(SECS_PER_HOUR));
      end else begin
        s4_hour <= s3_h0;
        s4_s2   <= hr[11:0];
      end
    end
  end

  // Stage 5: correct the year estimate; minute estimate.
  logic [31:0] ycyc;
  logic [30:0] yr_full;
  logic [18:0] yr;
  logic [22:0] prod_m;
  logic [13:0] s5_y;
  logic [21:0] s5_d;
  logic [5:0]  s5_m0;
  logic [11:0] s5_s2;
  logic [4:0]  s5_hour;
  logic [2:0]  s5_wday;

  assign ycyc    = 32'(s4_y0) * 32'(CYCLE_DAYS);
  assign yr_full = s4_n - ycyc[30:0];
  assign yr      = yr_full[18:0];
  assign prod_m  = 23'(s4_s2) * 23'(RECIP_60);

  always_ff @(posedge clk) begin
    if (pipe.en[5]) begin
      s5_y    <= (yr >= 19'(CYCLE_DAYS)) ? s4_y0 + 14'd1 : s4_y0;
      s5_d    <= s4_d;
      s5_m0   <= prod_m[21:16];
      s5_s2   <= s4_s2;
      s5_hour <= s4_hour;
      s5_wday <= s4_wday;
    end
  end

  // Stage 6: century count of the year; correct minute and second.
  logic [26:0] prod_c;
  logic [11:0] m60;
  logic [11:0] mr_full;
  logic [6:0]  mr;
  logic [13:0] s6_y;
  logic [21:0] s6_d;
  logic [7:0]  s6_q100;
  logic [5:0]  s6_min;
  logic [5:0]  s6_sec;
  logic [4:0]  s6_hour;
  logic [2:0]  s6_wday;

  assign prod_c  = 27'(s5_y) * 27'(RECIP_100);
  assign m60     = 12'(s5_m0) * 12'd60;
  assign mr_full = s5_s2 - m60;
  assign mr      = mr_full[6:0];

  always_ff @(posedge clk) begin
    if (pipe.en[6]) begin
      s6_y    <= s5_y;
      s6_d    <= s5_d;
      s6_q100 <= prod_c[26:19];
      if (mr >= 7'd60) begin
        s6_min <= s5_m0 + 6'd1;
        s6_sec <= 6'(mr - 7'd60);
      end else begin
        s6_min <= s5_m0;
        s6_sec <= mr[5:0];
      end
      s6_hour <= s5_hour;
      s6_wday <= s5_wday;
    end
  end

  // Stage 7: days before the estimated year, day of year, leap flag.
  logic [22:0] dby;
  logic [13:0] y100;
  logic        leap;
  logic [22:0] s7_yday;
  logic        s7_leap;
  logic [13:0] s7_y;
  logic [5:0]  s7_min;
  logic [5:0]  s7_sec;
  logic [4:0]  s7_hour;
  logic [2:0]  s7_wday;

  assign dby  = 23'(s6_y) * 23'd365 + 23'(s6_y[13:2]) - 23'(s6_q100)
              + 23'(s6_q100[7:2]);
  assign y100 = 14'(s6_q100) * 14'd100;
  assign leap = (s6_y[1:0] == 2'd0) && ((s6_y != y100) || (s6_q100[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    if (pipe.en[7]) begin
      s7_yday <= 23'(s6_d) - dby;
      s7_leap <= leap;
      s7_y    <= s6_y;
      s7_min  <= s6_min;
      s7_sec  <= s6_sec;
      s7_hour <= s6_hour;
      s7_wday <= s6_wday;
    end
  end

  // Stage 8: a negative day of year means the estimate was one year high.
  logic [22:0] yday_fix;
  logic [9:0]  s8_yday;
  logic [13:0] s8_y;
  logic [5:0]  s8_min;
  logic [5:0]  s8_sec;
  logic [4:0]  s8_hour;
  logic [2:0]  s8_wday;

  assign yday_fix = s7_yday + 23'd365 + 23'(s7_leap);

  always_ff @(posedge clk) begin
    if (pipe.en[8]) begin
      if (s7_yday[22]) begin
        s8_yday <= yday_fix[9:0];
        s8_y    <= s7_y - 14'd1;
      end else begin
        s8_yday <= s7_yday[9:0];
        s8_y    <= s7_y;
      end
      s8_min  <= s7_min;
      s8_sec  <= s7_sec;
      s8_hour <= s7_hour;
      s8_wday <= s7_wday;
    end
  end

  // Stage 9: March-based month.
  logic [13:0] mon_num;
  logic [25:0] prod_mo;
  logic [5:0]  s9_mon;
  logic [9:0]  s9_yday;
  logic [13:0] s9_y;
  logic [5:0]  s9_min;
  logic [5:0]  s9_sec;
  logic [4:0]  s9_hour;
  logic [2:0]  s9_wday;

  assign mon_num = (14'(s8_yday) + 14'd31) * 14'd10;
  assign prod_mo = 26'(mon_num) * 26'(RECIP_306);

  always_ff @(posedge clk) begin
    if (pipe.en[9]) begin
      s9_mon  <= prod_mo[25:20];
      s9_yday <= s8_yday;
      s9_y    <= s8_y;
      s9_min  <= s8_min;
      s9_sec  <= s8_sec;
      s9_hour <= s8_hour;
      s9_wday <= s8_wday;
    end
  end

  // Stage 10: day of month and the move back to January-based months.
  logic [9:0] mday;
  logic       past_feb;
  logic [5:0] mon_adj;

  assign mday     = s9_yday + 10'd31 - 10'(ecal_mon_start(s9_mon[3:0]));
  assign past_feb = s9_yday >= 10'(MARCH_YEAR_DAYS);
  assign mon_adj  = past_feb ? s9_mon - 6'd10 : s9_mon + 6'd2;

  always_ff @(posedge clk) begin
    if (pipe.en[10]) begin
      second       <= s9_sec;
      minute       <= s9_min;
      hour         <= s9_hour;
      day_of_month <= mday[4:0];
      month        <= mon_adj[3:0];
      year         <= past_feb ? s9_y + 14'd1 : s9_y;
      weekday      <= s9_wday;
    end
  end

endmodule
